@@ rtl/core/rgb2yuv_pkg.sv @@
`timescale 1ns / 1ps

package rgb2yuv_pkg;

  // Widths fixed by the register map and the pixel format
  localparam int CFG_W  = 13;   // widest register, also width/height registers
  localparam int PAIR_W = 12;   // row-pair registers
  localparam int ROW_W  = 12;   // row counter wraps at 4096
  localparam int POS_W  = 12;   // column/row fields in the result
  localparam int PIX_W  = 8;

  // Register index map
  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_BLUE_FIRST     = 3'd2,
    REG_SWAP_UV        = 3'd3,
    REG_FIRST_ROW_PAIR = 3'd4,
    REG_LAST_ROW_PAIR  = 3'd5
  } cfg_reg_t;

  // BT.601 weights, Q20
  typedef logic signed [20:0] weight_t;

  localparam weight_t W_RY = 21'sd269484;
  localparam weight_t W_GY = 21'sd528482;
  localparam weight_t W_BY = 21'sd102760;
  localparam weight_t W_RU = -21'sd155188;
  localparam weight_t W_GU = -21'sd305135;
  localparam weight_t W_BU = 21'sd460324;
  localparam weight_t W_RV = 21'sd460324;
  localparam weight_t W_GV = -21'sd385875;
  localparam weight_t W_BV = -21'sd74448;

  localparam longint Y_OFFSET = 64'sd16;
  localparam longint C_OFFSET = 64'sd128;

  // Position of the pixel handed from the counter block to the top
  typedef struct packed {
    logic [POS_W-1:0] pixel_column;
    logic [POS_W-1:0] pixel_row;
    logic             chroma_valid;
    logic             last_of_stripe;
  } pos_t;

endpackage

@@ rtl/core/rgb_to_yuv420_pixel_converter.sv @@
`timescale 1ns / 1ps
// Path: input register -> color math -> result register -> out_*.
// Throughput: one pixel per clock while out_tready stays high; input register -> color math -> result register.
// in_tready stays high while the result register is empty or being drained.
// Reset (rst_n low, synchronous): clears valids and the column/row counters and
// loads the registers with width 1, height 1, last_row_pair 1, all others 0.

module rgb_to_yuv420_pixel_converter #(
  parameter int MAX_WIDTH    = 4096,
  parameter int WEIGHT_SHIFT = 20
) (
  input  logic        clk,
  input  logic        rst_n,

  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [12:0] cfg_wdata,

  // Pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // chan0 [7:0], chan1 [15:8], chan2 [23:16]
  input  logic        in_tuser,    // start_of_stripe

  // Converted output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // luma [7:0], first_chroma [15:8],
                                   // second_chroma [23:16], pixel_column [35:24],
                                   // pixel_row [47:36]
  output logic        out_tuser,   // chroma_valid
  output logic        out_tlast    // last_of_stripe
);

  localparam int CW = rgb2yuv_pkg::CFG_W;
  localparam int PR = rgb2yuv_pkg::PAIR_W;
  localparam int PW = rgb2yuv_pkg::PIX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes to unused indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] image_width_r, image_height_r;
  logic          blue_first_r, swap_uv_r;
  logic [PR-1:0] first_row_pair_r, last_row_pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r    <= CW'(1);
      image_height_r   <= CW'(1);
      blue_first_r     <= 1'b0;
      swap_uv_r        <= 1'b0;
      first_row_pair_r <= '0;
      last_row_pair_r  <= PR'(1);
    end else if (cfg_wr_en) begin
      case (rgb2yuv_pkg::cfg_reg_t'(cfg_addr))
        rgb2yuv_pkg::REG_IMAGE_WIDTH:    image_width_r    <= cfg_wdata;
        rgb2yuv_pkg::REG_IMAGE_HEIGHT:   image_height_r   <= cfg_wdata;
        rgb2yuv_pkg::REG_BLUE_FIRST:     blue_first_r     <= cfg_wdata[0];
        rgb2yuv_pkg::REG_SWAP_UV:        swap_uv_r        <= cfg_wdata[0];
        rgb2yuv_pkg::REG_FIRST_ROW_PAIR: first_row_pair_r <= cfg_wdata[PR-1:0];
        rgb2yuv_pkg::REG_LAST_ROW_PAIR:  last_row_pair_r  <= cfg_wdata[PR-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. It advances into the result register whenever that one is
  // empty or being drained in the same cycle, so a beat can enter every clock.
  // ---------------------------------------------------------------------------
  logic          in_valid_r;
  logic          in_start_r;
  logic [PW-1:0] in_c0_r, in_c1_r, in_c2_r;
  logic          out_valid_r, out_valid_nxt;
  logic          s1_adv;
  logic          in_acc;

  assign s1_adv    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_start_r <= in_tuser;
      in_c0_r    <= in_tdata[7:0];
      in_c1_r    <= in_tdata[15:8];
      in_c2_r    <= in_tdata[23:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Column/row tracking. Counters step only when the pixel moves on, so they
  // follow the accepted order regardless of stalls.
  // ---------------------------------------------------------------------------
  rgb2yuv_pkg::pos_t pos;

  rgb2yuv_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (s1_adv),
    .start          (in_start_r),
    .image_width    (image_width_r),
    .image_height   (image_height_r),
    .first_row_pair (first_row_pair_r),
    .last_row_pair  (last_row_pair_r),
    .pos            (pos)
  );

  // ---------------------------------------------------------------------------
  // Color math: three constant-weight multiply-add trees with clamping.
  // Chroma is forced to zero off the even/even grid.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] luma, first_chroma, second_chroma;

  rgb2yuv_csc #(
    .WEIGHT_SHIFT (WEIGHT_SHIFT)
  ) u_csc (
    .chan0         (in_c0_r),
    .chan1         (in_c1_r),
    .chan2         (in_c2_r),
    .blue_first    (blue_first_r),
    .swap_uv       (swap_uv_r),
    .chroma_valid  (pos.chroma_valid),
    .luma          (luma),
    .first_chroma  (first_chroma),
    .second_chroma (second_chroma)
  );

  // ---------------------------------------------------------------------------
  // Result register: hold while the sink stalls, load on advance.
  // ---------------------------------------------------------------------------
  logic [47:0] out_data_r;
  logic        out_user_r, out_last_r;

  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {pos.pixel_row, pos.pixel_column, second_chroma, first_chroma, luma};
      out_user_r <= pos.chroma_valid;
      out_last_r <= pos.last_of_stripe;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Chroma only on even row and even column.
  a_chroma_grid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[24] && !out_tdata[36])
    else $error("chroma flagged on odd row or column");

  // Chroma bytes are zero off the grid.
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[23:8] == 16'd0)
    else $error("chroma bytes nonzero without chroma_valid");

  // Empty result register never blocks the input.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // A pixel leaving the input register shows up as a result next cycle.
  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_tvalid)
    else $error("advanced pixel lost");

endmodule

@@ rtl/core/rgb2yuv_pos.sv @@
`timescale 1ns / 1ps

module rgb2yuv_pos #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              advance,
  input  logic                              start,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]     image_width,
  input  logic [rgb2yuv_pkg::CFG_W-1:0]     image_height,
  input  logic [rgb2yuv_pkg::PAIR_W-1:0]    first_row_pair,
  input  logic [rgb2yuv_pkg::PAIR_W-1:0]    last_row_pair,
  output rgb2yuv_pkg::pos_t                 pos
);

  localparam int CW      = rgb2yuv_pkg::CFG_W;
  localparam int RW      = rgb2yuv_pkg::ROW_W;
  localparam int REG_MAX = (1 << CW) - 1;
  localparam int CAP     = (MAX_WIDTH > REG_MAX) ? REG_MAX : MAX_WIDTH;
  localparam int COL_W   = $clog2(CAP);
  localparam logic [CW-1:0] CAP_W = CW'(CAP);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;

  logic [CW-1:0]    eff_w;
  logic [COL_W-1:0] col_start, col_cur;
  logic [RW-1:0]    row_cur;
  logic [CW-1:0]    col_ext, col_inc;
  logic             wrap;
  logic [CW-1:0]    end_pair, end_row;
  logic             last;

  always_comb begin
    if (image_width == '0) begin
      eff_w = CW'(1);
    end else if (image_width > CAP_W) begin
      eff_w = CAP_W;
    end else begin
      eff_w = image_width;
    end

    col_start = start ? '0 : col_r;
    row_cur   = start ? {first_row_pair[RW-2:0], 1'b0} : row_r;
    col_cur   = (CW'(col_start) >= eff_w) ? '0 : col_start;
    col_ext   = CW'(col_cur);
    col_inc   = col_ext + CW'(1);
    wrap      = col_inc >= eff_w;

    end_pair = {last_row_pair, 1'b0};
    end_row  = (end_pair > image_height) ? image_height : end_pair;
    last     = (end_row != '0) && (CW'(row_cur) == end_row - CW'(1)) &&
               (col_ext == eff_w - CW'(1));

    col_nxt = wrap ? '0 : col_inc[COL_W-1:0];
    row_nxt = wrap ? row_cur + RW'(1) : row_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign pos.pixel_column   = col_ext[rgb2yuv_pkg::POS_W-1:0];
  assign pos.pixel_row      = row_cur;
  assign pos.chroma_valid   = !row_cur[0] && !col_cur[0];
  assign pos.last_of_stripe = last;

endmodule

@@ rtl/core/rgb2yuv_csc.sv @@
`timescale 1ns / 1ps

module rgb2yuv_csc #(
  parameter int WEIGHT_SHIFT = 20
) (
  input  logic [rgb2yuv_pkg::PIX_W-1:0] chan0,
  input  logic [rgb2yuv_pkg::PIX_W-1:0] chan1,
  input  logic [rgb2yuv_pkg::PIX_W-1:0] chan2,
  input  logic                          blue_first,
  input  logic                          swap_uv,
  input  logic                          chroma_valid,
  output logic [rgb2yuv_pkg::PIX_W-1:0] luma,
  output logic [rgb2yuv_pkg::PIX_W-1:0] first_chroma,
  output logic [rgb2yuv_pkg::PIX_W-1:0] second_chroma
);

  localparam int PW    = rgb2yuv_pkg::PIX_W;
  localparam int PROD_W = 30;
  localparam int SUM_W = ((WEIGHT_SHIFT > 20) ? WEIGHT_SHIFT : 20) + 12;
  localparam longint HALF = 64'sd1 << (WEIGHT_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] Y_BIAS =
    SUM_W'((rgb2yuv_pkg::Y_OFFSET << WEIGHT_SHIFT) + HALF);
  localparam logic signed [SUM_W-1:0] C_BIAS =
    SUM_W'((rgb2yuv_pkg::C_OFFSET << WEIGHT_SHIFT) + HALF);

  // Floor-shift, then clamp to 0..255
  function automatic logic [PW-1:0] sat8(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] q;
    q = s >>> WEIGHT_SHIFT;
    if (s < 0) begin
      sat8 = '0;
    end else if (q > SUM_W'(255)) begin
      sat8 = '1;
    end else begin
      sat8 = q[PW-1:0];
    end
  endfunction

  logic signed [PW:0]       r_s, g_s, b_s;
  logic signed [PROD_W-1:0] p_ry, p_gy, p_by, p_ru, p_gu, p_bu, p_rv, p_gv, p_bv;
  logic signed [SUM_W-1:0]  y_sum, u_sum, v_sum;
  logic [PW-1:0]            u_val, v_val;

  always_comb begin
    r_s = $signed({1'b0, blue_first ? chan2 : chan0});
    g_s = $signed({1'b0, chan1});
    b_s = $signed({1'b0, blue_first ? chan0 : chan2});

    p_ry = rgb2yuv_pkg::W_RY * r_s;
    p_gy = rgb2yuv_pkg::W_GY * g_s;
    p_by = rgb2yuv_pkg::W_BY * b_s;
    p_ru = rgb2yuv_pkg::W_RU * r_s;
    p_gu = rgb2yuv_pkg::W_GU * g_s;
    p_bu = rgb2yuv_pkg::W_BU * b_s;
    p_rv = rgb2yuv_pkg::W_RV * r_s;
    p_gv = rgb2yuv_pkg::W_GV * g_s;
    p_bv = rgb2yuv_pkg::W_BV * b_s;

    y_sum = SUM_W'(p_ry) + SUM_W'(p_gy) + SUM_W'(p_by) + Y_BIAS;
    u_sum = SUM_W'(p_ru) + SUM_W'(p_gu) + SUM_W'(p_bu) + C_BIAS;
    v_sum = SUM_W'(p_rv) + SUM_W'(p_gv) + SUM_W'(p_bv) + C_BIAS;

    luma  = sat8(y_sum);
    u_val = chroma_valid ? sat8(u_sum) : '0;
    v_val = chroma_valid ? sat8(v_sum) : '0;

    first_chroma  = swap_uv ? v_val : u_val;
    second_chroma = swap_uv ? u_val : v_val;
  end

endmodule

@@ bench/tb_rgb_to_yuv420_pixel_converter.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the RGB to YUV 4:2:0 pixel converter.
// A queue of pixels feeds a clocked driver; every accepted beat is run through a
// local BT.601 predictor and the result is queued. A clocked monitor pops one
// expectation per result beat and checks it field by field.
module tb_rgb_to_yuv420_pixel_converter;

  localparam int CLK_HALF      = 10;
  localparam int Q_SHIFT       = 20;
  localparam int MAX_W         = 4096;
  localparam int SETTLE_CYCLES = 8;       // extra wait once the queues have drained
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_PIXELS  = 46;
  localparam int WIDE_PIXELS   = 120;

  // Register slots past the map; writes there must not disturb anything
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // BT.601 weights in Q20
  localparam longint K_RY = 269484;
  localparam longint K_GY = 528482;
  localparam longint K_BY = 102760;
  localparam longint K_RU = -155188;
  localparam longint K_GU = -305135;
  localparam longint K_BU = 460324;
  localparam longint K_RV = 460324;
  localparam longint K_GV = -385875;
  localparam longint K_BV = -74448;
  localparam longint LUMA_BIAS   = 16;
  localparam longint CHROMA_BIAS = 128;

  // Primaries, secondaries, black and white
  localparam logic [23:0] CORNER_RGB [8] = '{
    24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00,
    24'hFF0000, 24'hFFFF00, 24'hFF00FF, 24'h00FFFF
  };

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic       sos;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  luma;
    logic        chroma_valid;
    logic [7:0]  first_chroma;
    logic [7:0]  second_chroma;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        last_of_stripe;
  } yuv_beat_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_addr  = rgb2yuv_pkg::REG_IMAGE_WIDTH;
  logic [12:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata  = '0;   // chan0 [7:0], chan1 [15:8], chan2 [23:16]
  logic        in_tuser  = 1'b0; // start_of_stripe
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;        // luma, first_chroma, second_chroma, column, row
  logic        out_tuser;        // chroma_valid
  logic        out_tlast;        // last_of_stripe

  // Shadow of the register file, at reset values
  logic [12:0] reg_width      = 13'd1;
  logic [12:0] reg_height     = 13'd1;
  logic        reg_blue_first = 1'b0;
  logic        reg_swap_uv    = 1'b0;
  logic [11:0] reg_first_pair = 12'd0;
  logic [11:0] reg_last_pair  = 12'd1;

  // Predicted raster position
  int unsigned stripe_col = 0;
  int unsigned stripe_row = 0;

  pixel_t    pixel_q[$];
  yuv_beat_t yuv_expect_q[$];

  int gap_pct        = 0;
  int stall_pct      = 0;
  int long_hold_req  = 0;
  int long_hold_seen = 0;
  int hold_left      = 0;
  int error_count    = 0;
  int beats_checked  = 0;
  int chroma_beats   = 0;
  int stripe_ends    = 0;
  int settings_run   = 0;
  int cycle_count    = 0;

  rgb_to_yuv420_pixel_converter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Rounded Q20 weighted sum plus bias, floored, clamped to a byte
  function automatic logic [7:0] bt601_mix(longint wr, longint wg, longint wb,
                                           longint r, longint g, longint b,
                                           longint bias);
    longint acc;
    acc = wr * r + wg * g + wb * b + (longint'(1) << (Q_SHIFT - 1))
        + bias * (longint'(1) << Q_SHIFT);
    if (acc < 0) return 8'd0;
    acc = acc >>> Q_SHIFT;
    if (acc > 255) return 8'd255;
    return acc[7:0];
  endfunction

  // Convert one accepted pixel and advance the raster position
  function automatic yuv_beat_t convert_pixel(logic sos, logic [23:0] rgb);
    int unsigned w;
    int unsigned end_row;
    longint      r;
    longint      g;
    longint      b;
    logic [7:0]  u;
    logic [7:0]  v;
    yuv_beat_t   res;
    w = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : reg_width);
    r = reg_blue_first ? rgb[23:16] : rgb[7:0];
    g = rgb[15:8];
    b = reg_blue_first ? rgb[7:0] : rgb[23:16];
    if (sos) begin
      stripe_col = 0;
      stripe_row = (2 * reg_first_pair) % 4096;
    end
    if (stripe_col >= w) stripe_col = 0;
    end_row = 2 * reg_last_pair;
    if (end_row > reg_height) end_row = reg_height;
    res = '0;
    res.luma = bt601_mix(K_RY, K_GY, K_BY, r, g, b, LUMA_BIAS);
    res.chroma_valid = (stripe_row[0] == 1'b0) && (stripe_col[0] == 1'b0);
    if (res.chroma_valid) begin
      u = bt601_mix(K_RU, K_GU, K_BU, r, g, b, CHROMA_BIAS);
      v = bt601_mix(K_RV, K_GV, K_BV, r, g, b, CHROMA_BIAS);
      res.first_chroma  = reg_swap_uv ? v : u;
      res.second_chroma = reg_swap_uv ? u : v;
    end
    res.pixel_column   = stripe_col[11:0];
    res.pixel_row      = stripe_row[11:0];
    res.last_of_stripe = (end_row != 0) && (stripe_row == end_row - 1)
                         && (stripe_col == w - 1);
    stripe_col++;
    if (stripe_col >= w) begin
      stripe_col = 0;
      stripe_row = (stripe_row + 1) % 4096;
    end
    return res;
  endfunction

  // Bias toward the byte extremes now and then
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7, 0))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic pixel_t rand_pixel(logic sos);
    pixel_t px;
    px.sos = sos;
    px.c0  = rand_byte();
    px.c1  = rand_byte();
    px.c2  = rand_byte();
    return px;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("MISMATCH beat %0d %s: got %0d, expected %0d", beats_checked, what, got, want);
  endtask

  // One write beat; the caller lowers the enable after the last one
  task automatic put_reg(logic [2:0] idx, logic [12:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      rgb2yuv_pkg::REG_IMAGE_WIDTH:    reg_width      = val;
      rgb2yuv_pkg::REG_IMAGE_HEIGHT:   reg_height     = val;
      rgb2yuv_pkg::REG_BLUE_FIRST:     reg_blue_first = val[0];
      rgb2yuv_pkg::REG_SWAP_UV:        reg_swap_uv    = val[0];
      rgb2yuv_pkg::REG_FIRST_ROW_PAIR: reg_first_pair = val[11:0];
      rgb2yuv_pkg::REG_LAST_ROW_PAIR:  reg_last_pair  = val[11:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(logic [12:0] w, logic [12:0] h, logic blue, logic swap,
                              logic [12:0] first, logic [12:0] last);
    put_reg(REG_SPARE_6, 13'($urandom));
    put_reg(rgb2yuv_pkg::REG_IMAGE_WIDTH, w);
    put_reg(rgb2yuv_pkg::REG_IMAGE_HEIGHT, h);
    put_reg(rgb2yuv_pkg::REG_BLUE_FIRST, {12'd0, blue});
    put_reg(rgb2yuv_pkg::REG_SWAP_UV, {12'd0, swap});
    put_reg(rgb2yuv_pkg::REG_FIRST_ROW_PAIR, first);
    put_reg(rgb2yuv_pkg::REG_LAST_ROW_PAIR, last);
    put_reg(REG_SPARE_7, 13'($urandom));
    cfg_wr_en <= 1'b0;
    settings_run++;
  endtask

  task automatic set_idling(idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin gap_pct = 70; stall_pct = 0;  end
      IDLE_RECV: begin gap_pct = 0;  stall_pct = 70; end
      IDLE_BOTH: begin gap_pct = 16; stall_pct = 16; end
      default:   begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // Queue count pixels laid out in stripes for the current settings, with a few stray restarts
  task automatic queue_stripes(int count);
    int unsigned w;
    int unsigned start_row;
    int unsigned end_row;
    int unsigned span;
    int unsigned pos;
    @(negedge clk);
    w = (reg_width == 0) ? 1 : ((reg_width > MAX_W) ? MAX_W : reg_width);
    start_row = (2 * reg_first_pair) % 4096;
    end_row = 2 * reg_last_pair;
    if (end_row > reg_height) end_row = reg_height;
    // With no rows in the stripe, run a few rows past its end instead
    span = (end_row > start_row) ? w * (end_row - start_row) : w * $urandom_range(3, 1);
    pos = 0;
    repeat (count) begin
      pixel_q.push_back(rand_pixel(pos == 0 || $urandom_range(99, 0) < 4));
      pos = (pos + 1 >= span) ? 0 : pos + 1;
    end
  endtask

  // Hold until the queue is empty and every expected result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_q.size() != 0 || in_tvalid || yuv_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: predict on each accepted beat, then offer the next pixel or idle.
  // A beat on offer is held until taken; gaps are only rolled between beats.
  always @(posedge clk) begin : drive_pixels
    pixel_t px;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        yuv_expect_q.push_back(convert_pixel(in_tuser, in_tdata));
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && $urandom_range(99, 0) >= gap_pct) begin
          px = pixel_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {px.c2, px.c1, px.c0};
          in_tuser  <= px.sos;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expectation, then
  // decide tready for the next cycle. A long hold-off request drops tready
  // until hold_left, loaded from LONG_HOLD, runs out, so the converter backs up into its input.
  always @(posedge clk) begin : check_results
    yuv_beat_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        beats_checked++;
        if (yuv_expect_q.size() == 0) begin
          report_mismatch("beat with nothing expected, luma", out_tdata[7:0], 0);
        end else begin
          want = yuv_expect_q.pop_front();
          if (out_tdata[7:0] !== want.luma)
            report_mismatch("luma", out_tdata[7:0], want.luma);
          if (out_tuser !== want.chroma_valid)
            report_mismatch("chroma_valid", out_tuser, want.chroma_valid);
          if (out_tdata[15:8] !== want.first_chroma)
            report_mismatch("first_chroma", out_tdata[15:8], want.first_chroma);
          if (out_tdata[23:16] !== want.second_chroma)
            report_mismatch("second_chroma", out_tdata[23:16], want.second_chroma);
          if (out_tdata[35:24] !== want.pixel_column)
            report_mismatch("pixel_column", out_tdata[35:24], want.pixel_column);
          if (out_tdata[47:36] !== want.pixel_row)
            report_mismatch("pixel_row", out_tdata[47:36], want.pixel_row);
          if (out_tlast !== want.last_of_stripe)
            report_mismatch("last_of_stripe", out_tlast, want.last_of_stripe);
          if (want.chroma_valid) chroma_beats++;
          if (want.last_of_stripe) stripe_ends++;
        end
      end
      if (long_hold_req != long_hold_seen) begin
        long_hold_seen = long_hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, yuv_expect_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : run_test
    logic [12:0] w;
    logic [12:0] h;
    logic [12:0] first;
    logic [12:0] last;
    set_idling(IDLE_NONE);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset registers: width 1, so every pixel is its own row
    @(negedge clk);
    foreach (CORNER_RGB[i]) pixel_q.push_back(pixel_t'({1'b0, CORNER_RGB[i]}));
    wait_drained();

    // BGR input, YV12 order, a 4x4 stripe inside a 6-row image
    @(posedge clk);
    program_regs(13'd4, 13'd6, 1'b1, 1'b1, 13'd0, 13'd2);
    @(negedge clk);
    foreach (CORNER_RGB[i]) pixel_q.push_back(pixel_t'({i == 0, CORNER_RGB[i]}));
    repeat (8) pixel_q.push_back(rand_pixel(1'b0));
    wait_drained();

    // Width above the maximum: columns run on with no early wrap; start pair
    // 2048 wraps to row 0. Hold off the receiver early so the converter fills
    // and stalls its input.
    @(posedge clk);
    program_regs(13'h1FFF, 13'd1, 1'b1, 1'b0, 13'h1800, 13'd1);
    queue_stripes(WIDE_PIXELS);
    long_hold_req++;
    wait_drained();

    // Stripe starting at row 4094: the row counter wraps past 4095
    @(posedge clk);
    program_regs(13'd3, 13'h1FFF, 1'b0, 1'b1, 13'h07FF, 13'h1FFF);
    set_idling(IDLE_BOTH);
    queue_stripes(15);
    wait_drained();

    // Random settings, cycling through the idling patterns
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(5, 0))
        0:       w = 13'd0;
        1:       w = 13'($urandom_range(16, 5));
        default: w = 13'($urandom_range(4, 1));
      endcase
      case ($urandom_range(5, 0))
        0:       h = 13'd0;
        1:       h = 13'h1FFF;
        default: h = 13'($urandom_range(12, 1));
      endcase
      first = ($urandom_range(7, 0) == 0) ? 13'($urandom) : 13'($urandom_range(3, 0));
      case ($urandom_range(7, 0))
        0:       last = 13'd0;
        1:       last = 13'h1FFF;
        default: last = 13'($urandom_range(7, 1));
      endcase
      @(posedge clk);
      program_regs(w, h, 1'($urandom), 1'($urandom), first, last);
      set_idling(idle_mode_t'(phase % 4));
      if (phase % 2 == 0) begin
        // Pause the sender mid-phase until the pipeline is empty
        queue_stripes(PHASE_PIXELS / 2);
        wait_drained();
        queue_stripes(PHASE_PIXELS - PHASE_PIXELS / 2);
      end else begin
        queue_stripes(PHASE_PIXELS);
      end
      wait_drained();
    end

    $display("Checked %0d result beats under %0d register settings", beats_checked,
             settings_run);
    $display("  %0d beats carried chroma, %0d marked a stripe end", chroma_beats,
             stripe_ends);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
